// ===== hw/rtl/ps2s1_pkg.sv =====
// Shared types, byte codes and result layout for the scan code set 1 decoder.
`default_nettype none

package ps2s1_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned KeyW  = 7;
  localparam int unsigned ModW  = 6;

  // Scan code bytes that the decoder recognizes.
  localparam logic [CodeW-1:0] ScLShiftMake  = 8'h2A;
  localparam logic [CodeW-1:0] ScRShiftMake  = 8'h36;
  localparam logic [CodeW-1:0] ScLShiftBreak = 8'hAA;
  localparam logic [CodeW-1:0] ScRShiftBreak = 8'hB6;
  localparam logic [CodeW-1:0] ScExtPrefix   = 8'hE0;
  localparam logic [CodeW-1:0] ScPausePrefix = 8'hE1;
  localparam logic [CodeW-1:0] ScCtrlMake    = 8'h1D;
  localparam logic [CodeW-1:0] ScCtrlBreak   = 8'h9D;
  localparam logic [CodeW-1:0] ScAltMake     = 8'h38;
  localparam logic [CodeW-1:0] ScAltBreak    = 8'hB8;
  localparam logic [CodeW-1:0] ScPrtScBreak  = 8'hB7;
  localparam logic [CodeW-1:0] ScPrtScMake   = 8'h37;
  localparam logic [CodeW-1:0] ScNumLock     = 8'h45;
  localparam logic [CodeW-1:0] ScNumLockBrk  = 8'hC5;

  // Modifier bit positions.
  localparam logic [ModW-1:0] ModLShift = 6'h01;
  localparam logic [ModW-1:0] ModRShift = 6'h02;
  localparam logic [ModW-1:0] ModRCtrl  = 6'h08;
  localparam logic [ModW-1:0] ModRAlt   = 6'h20;

  typedef enum logic [3:0] {
    StStart  = 4'd0,
    StExt    = 4'd1,
    StPsp2   = 4'd2,
    StPsp3   = 4'd3,
    StPsr2   = 4'd4,
    StPsr3   = 4'd5,
    StPause1 = 4'd6,
    StPause2 = 4'd7,
    StPause3 = 4'd8,
    StPause4 = 4'd9,
    StPause5 = 4'd10
  } dec_state_e;

  typedef enum logic [1:0] {
    EvKey       = 2'd0,
    EvPsPress   = 2'd1,
    EvPsRelease = 2'd2,
    EvPause     = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e       kind;
    logic [KeyW-1:0]   key_code;
    logic              shift;
    logic [ModW-1:0]   mods;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ps2s1_in_reg.sv =====
// Input register stage holding one scan code byte until it is decoded.
`default_nettype none

module ps2s1_in_reg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ps2s1_pkg::CodeW-1:0] scan_code_i,
  input  wire logic                        advance_i,
  output logic                             valid_o,
  output logic [ps2s1_pkg::CodeW-1:0]      code_o
);

  logic                        valid_q, valid_d;
  logic [ps2s1_pkg::CodeW-1:0] code_q, code_d;
  logic                        take;

  // The stage may refill in the same cycle that its byte moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    code_d  = code_q;
    if (take) begin
      valid_d = 1'b1;
      code_d  = scan_code_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ps2s1_decode.sv =====
// Sequence state machine and held modifier flags for scan code set 1.
`default_nettype none

module ps2s1_decode (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [ps2s1_pkg::CodeW-1:0] code_i,
  output logic                             emit_o,
  output ps2s1_pkg::result_t               result_o
);

  ps2s1_pkg::dec_state_e       state_q, state_d;
  logic [ps2s1_pkg::ModW-1:0]  mods_q, mods_d;
  logic                        emit;
  ps2s1_pkg::event_kind_e      kind;

  // Next state and modifier update.
  always_comb begin
    state_d = ps2s1_pkg::StStart;
    mods_d  = mods_q;
    case (state_q)
      ps2s1_pkg::StStart: begin
        case (code_i)
          ps2s1_pkg::ScLShiftMake:  mods_d = mods_q | ps2s1_pkg::ModLShift;
          ps2s1_pkg::ScRShiftMake:  mods_d = mods_q | ps2s1_pkg::ModRShift;
          ps2s1_pkg::ScLShiftBreak: mods_d = mods_q & ~ps2s1_pkg::ModLShift;
          ps2s1_pkg::ScRShiftBreak: mods_d = mods_q & ~ps2s1_pkg::ModRShift;
          ps2s1_pkg::ScExtPrefix:   state_d = ps2s1_pkg::StExt;
          ps2s1_pkg::ScPausePrefix: state_d = ps2s1_pkg::StPause1;
          default: ;
        endcase
      end
      ps2s1_pkg::StExt: begin
        case (code_i)
          ps2s1_pkg::ScCtrlMake:   mods_d = mods_q | ps2s1_pkg::ModRCtrl;
          ps2s1_pkg::ScCtrlBreak:  mods_d = mods_q & ~ps2s1_pkg::ModRCtrl;
          ps2s1_pkg::ScAltMake:    mods_d = mods_q | ps2s1_pkg::ModRAlt;
          ps2s1_pkg::ScAltBreak:   mods_d = mods_q & ~ps2s1_pkg::ModRAlt;
          ps2s1_pkg::ScLShiftMake: state_d = ps2s1_pkg::StPsp2;
          ps2s1_pkg::ScPrtScBreak: state_d = ps2s1_pkg::StPsr2;
          default: ;
        endcase
      end
      ps2s1_pkg::StPsp2: begin
        if (code_i == ps2s1_pkg::ScExtPrefix) state_d = ps2s1_pkg::StPsp3;
      end
      ps2s1_pkg::StPsr2: begin
        if (code_i == ps2s1_pkg::ScExtPrefix) state_d = ps2s1_pkg::StPsr3;
      end
      ps2s1_pkg::StPause1: begin
        if (code_i == ps2s1_pkg::ScCtrlMake) state_d = ps2s1_pkg::StPause2;
      end
      ps2s1_pkg::StPause2: begin
        if (code_i == ps2s1_pkg::ScNumLock) state_d = ps2s1_pkg::StPause3;
      end
      ps2s1_pkg::StPause3: begin
        if (code_i == ps2s1_pkg::ScPausePrefix) state_d = ps2s1_pkg::StPause4;
      end
      ps2s1_pkg::StPause4: begin
        if (code_i == ps2s1_pkg::ScCtrlBreak) state_d = ps2s1_pkg::StPause5;
      end
      default: ;
    endcase
  end

  // Event detection; modifiers are unchanged on any byte that emits.
  always_comb begin
    emit = 1'b0;
    kind = ps2s1_pkg::EvKey;
    case (state_q)
      ps2s1_pkg::StStart: begin
        if (!code_i[ps2s1_pkg::CodeW-1]
            && code_i != ps2s1_pkg::ScLShiftMake
            && code_i != ps2s1_pkg::ScRShiftMake) begin
          emit = 1'b1;
        end
      end
      ps2s1_pkg::StPsp3: begin
        emit = (code_i == ps2s1_pkg::ScPrtScMake);
        kind = ps2s1_pkg::EvPsPress;
      end
      ps2s1_pkg::StPsr3: begin
        emit = (code_i == ps2s1_pkg::ScLShiftBreak);
        kind = ps2s1_pkg::EvPsRelease;
      end
      ps2s1_pkg::StPause5: begin
        emit = (code_i == ps2s1_pkg::ScNumLockBrk);
        kind = ps2s1_pkg::EvPause;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.kind     = kind;
    result_o.key_code = (kind == ps2s1_pkg::EvKey) ? code_i[ps2s1_pkg::KeyW-1:0]
                                                   : '0;
    result_o.shift    = |(mods_q & (ps2s1_pkg::ModLShift | ps2s1_pkg::ModRShift));
    result_o.mods     = mods_q;
  end

  assign emit_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2s1_pkg::StStart;
      mods_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      mods_q  <= mods_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ps2s1_out_reg.sv =====
// Result register that holds one decoded event until it is taken.
`default_nettype none

module ps2s1_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  ps2s1_pkg::result_t      result_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ps2s1_pkg::result_t      result_o
);

  logic               valid_q, valid_d;
  ps2s1_pkg::result_t data_q, data_d;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ps2_set1_scancode_decoder.sv =====
// Scan code set 1 decoder: two-stage request pipeline around the sequence decoder.
// Path: a request waits in the input stage until the result register has room, is then
// decoded and, if it completes an event, loaded there. Throughput: one request per cycle
// while the result register has room, limited by the single decode step per byte.
// Reset: rst_ni clears both valid flags, returns the decoder to its start state and
// clears all held modifier flags; the data registers are not reset.
`default_nettype none

module ps2_set1_scancode_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ps2s1_pkg::CodeW-1:0] scan_code_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       event_kind_o,
  output logic [ps2s1_pkg::KeyW-1:0]       key_code_o,
  output logic                             shift_active_o,
  output logic [ps2s1_pkg::ModW-1:0]       modifier_flags_o
);

  logic                        stage_valid;
  logic [ps2s1_pkg::CodeW-1:0] stage_code;
  logic                        out_free;
  logic                        advance;
  logic                        emit;
  ps2s1_pkg::result_t          dec_result;
  ps2s1_pkg::result_t          out_result;

  // A byte in the input stage is decoded once the result register has room,
  // either because it is empty or because its event is being taken this cycle.
  // Bytes that produce no event still wait for that room, which keeps ordering
  // simple and costs nothing at one request per cycle.
  assign advance = stage_valid && out_free;

  ps2s1_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .scan_code_i (scan_code_i),
    .advance_i   (advance),
    .valid_o     (stage_valid),
    .code_o      (stage_code)
  );

  // The decoder advances its state only when a byte is consumed.
  ps2s1_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .code_i   (stage_code),
    .emit_o   (emit),
    .result_o (dec_result)
  );

  ps2s1_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .result_i    (dec_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign event_kind_o     = out_result.kind;
  assign key_code_o       = out_result.key_code;
  assign shift_active_o   = out_result.shift;
  assign modifier_flags_o = out_result.mods;

endmodule

`default_nettype wire
